// ===== rtl/stereo_preemphasis_agc_scaler_top_defines.svh =====
// Assertion macros for the stereo pre-emphasis / AGC scaler.
// Included by the top level; depends on nothing else.
`ifndef STEREO_PREEMPHASIS_AGC_SCALER_TOP_DEFINES_SVH
`define STEREO_PREEMPHASIS_AGC_SCALER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPAS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spas_pkg.sv =====
// Shared constants, register indexes and types for the stereo scaler.
// No dependencies.
`default_nettype none

package spas_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int POWER_BITS  = 48;
    localparam int ROOT_BITS   = 31;
    localparam int QUOT_BITS   = 47;
    localparam int TOT_BITS    = 63;
    localparam int SQRT_STEPS  = 31;
    localparam int DIV_STEPS   = 47;
    localparam int CNT_BITS    = 6;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 48;

    localparam logic [ADDR_BITS-1:0] REG_PREEMPH_ENABLE = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_PREEMPH_COEF   = 3'd1;
    localparam logic [ADDR_BITS-1:0] REG_RMS_NORM_EN    = 3'd2;
    localparam logic [ADDR_BITS-1:0] REG_AGC_DECAY      = 3'd3;
    localparam logic [ADDR_BITS-1:0] REG_AGC_INIT_POWER = 3'd4;
    localparam logic [ADDR_BITS-1:0] REG_LEVEL_ENABLE   = 3'd5;
    localparam logic [ADDR_BITS-1:0] REG_LEVEL_GAIN     = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] left_out;
        logic signed [31:0] right_out;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic        preemph_enable;
        logic [15:0] preemph_coef;
        logic [15:0] agc_decay;
        logic        level_enable;
        logic [31:0] level_gain;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic square;
        logic smooth_a;
        logic smooth_b;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic bypass;
        logic lv_lo;
        logic lv_hi;
        logic lv_sum;
        logic pow_load;
    } lane_ctl_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/spas_lane.sv =====
// One channel lane: pre-emphasis, power smoother, iterative root and divide, level gain.
// Depends on spas_pkg.
`default_nettype none

module spas_lane (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire spas_pkg::cfg_t                         cfg,
    input  wire spas_pkg::lane_ctl_t                    ctl,
    input  wire logic [spas_pkg::POWER_BITS-1:0]        pow_init,
    input  wire logic signed [spas_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [31:0]                            divisor,
    output logic [spas_pkg::ROOT_BITS-1:0]              root,
    output spas_pkg::lane_res_t                         res
);

    localparam int S   = spas_pkg::SAMPLE_BITS;
    localparam int YW  = S + 18;
    localparam int MW  = S + 17;
    localparam int SH  = S - 15;
    localparam int SHR = (SH > 0) ? SH : 1;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam int PW  = spas_pkg::POWER_BITS;
    localparam int QW  = spas_pkg::QUOT_BITS;
    localparam int TW  = spas_pkg::TOT_BITS;

    logic signed [S-1:0] prev_reg;
    logic [31:0]         work_reg;
    logic                neg_reg;
    logic [PW-1:0]       sq_reg;
    logic [63:0]         acc_reg;
    logic [PW-1:0]       pow_reg;
    logic [61:0]         v_reg;
    logic [32:0]         rem_reg;
    logic [30:0]         root_reg;
    logic [31:0]         drem_reg;
    logic [QW-1:0]       dv_reg;
    logic [55:0]         plo_reg;
    logic [54:0]         phi_reg;
    logic [TW-1:0]       tot_reg;

    logic signed [YW-1:0] y_prod;
    logic signed [YW-1:0] y;
    logic [MW-1:0]        umag;
    logic [31:0]          work_next;
    logic [63:0]          sq_full;
    logic [PW-1:0]        sq_next;
    logic [16:0]          gain_b;
    logic [64:0]          bs_prod;
    logic [64:0]          sm_sum;
    logic [34:0]          rt_new;
    logic [34:0]          rt_trial;
    logic [32:0]          dv_try;
    logic [78:0]          lv_full;
    logic [TW-1:0]        lim;
    logic                 over;
    logic [31:0]          q32;

    always_comb begin
        y_prod = YW'($signed({1'b0, cfg.preemph_coef})) * YW'(prev_reg);
        y      = (YW'(sample) <<< 16) - (cfg.preemph_enable ? y_prod : '0);
        umag   = y[YW-1] ? MW'(-y) : MW'(y);
    end

    // Bring the magnitude to 30 fraction bits, rounding half away from zero.
    generate
        if (SH > 0) begin : g_shr
            logic [MW:0] rnd;
            assign rnd       = (MW+1)'(umag) + (MW+1)'(1 << (SHR - 1));
            assign work_next = 32'(rnd >> SHR);
        end else begin : g_shl
            assign work_next = 32'(umag) << SHL;
        end
    endgenerate

    always_comb begin
        sq_full  = work_reg * work_reg;
        sq_next  = (sq_full[63:62] != 2'b00) ? '1 : sq_full[61:14];
        gain_b   = 17'h10000 - {1'b0, cfg.agc_decay};
        bs_prod  = gain_b * sq_reg;
        sm_sum   = 65'(acc_reg) + bs_prod + 65'(32768);
        rt_new   = {rem_reg, v_reg[61:60]};
        rt_trial = {2'b00, root_reg, 2'b01};
        dv_try   = {drem_reg, dv_reg[QW-1]};
        lv_full  = {phi_reg, 24'b0} + 79'(plo_reg) + 79'(32768);
        lim      = neg_reg ? TW'(64'h8000_0000) : TW'(64'h7FFF_FFFF);
        over     = tot_reg > lim;
        q32      = over ? lim[31:0] : tot_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            pow_reg  <= '0;
        end else begin
            if (ctl.load) begin
                prev_reg <= sample;
            end
            if (ctl.pow_load) begin
                pow_reg <= pow_init;
            end else if (ctl.smooth_b) begin
                pow_reg <= PW'(sm_sum >> 16);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            work_reg <= work_next;
            neg_reg  <= y[YW-1];
        end
        if (ctl.square) begin
            sq_reg <= sq_next;
        end
        if (ctl.smooth_a) begin
            acc_reg <= cfg.agc_decay * pow_reg;
        end
        if (ctl.sqrt_init) begin
            v_reg    <= {pow_reg, 14'b0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (ctl.sqrt_step) begin
            v_reg <= {v_reg[59:0], 2'b00};
            if (rt_new >= rt_trial) begin
                rem_reg  <= 33'(rt_new - rt_trial);
                root_reg <= {root_reg[29:0], 1'b1};
            end else begin
                rem_reg  <= 33'(rt_new);
                root_reg <= {root_reg[29:0], 1'b0};
            end
        end
        if (ctl.div_init) begin
            dv_reg   <= QW'({work_reg, 15'b0}) + QW'(divisor >> 1);
            drem_reg <= '0;
        end else if (ctl.div_step) begin
            if (dv_try >= {1'b0, divisor}) begin
                drem_reg <= 32'(dv_try - {1'b0, divisor});
                dv_reg   <= {dv_reg[QW-2:0], 1'b1};
            end else begin
                drem_reg <= dv_try[31:0];
                dv_reg   <= {dv_reg[QW-2:0], 1'b0};
            end
        end else if (ctl.bypass) begin
            dv_reg <= QW'((33'(work_reg) + 33'(16384)) >> 15);
        end
        if (ctl.lv_lo) begin
            plo_reg <= dv_reg[23:0] * cfg.level_gain;
        end
        if (ctl.lv_hi) begin
            phi_reg <= dv_reg[QW-1:24] * cfg.level_gain;
        end
        if (ctl.lv_sum) begin
            tot_reg <= cfg.level_enable ? lv_full[78:16] : TW'(dv_reg);
        end
    end

    assign root      = root_reg;
    assign res.value = neg_reg ? 32'(-q32) : q32;
    assign res.sat   = over;

endmodule

`default_nettype wire

// ===== rtl/spas_merge.sv =====
// Merge stage: larger of the two lane roots plus one LSB, registered as the divisor.
// Depends on spas_pkg.
`default_nettype none

module spas_merge (
    input  wire logic                            aclk,
    input  wire logic                            capture,
    input  wire logic [spas_pkg::ROOT_BITS-1:0]  root_l,
    input  wire logic [spas_pkg::ROOT_BITS-1:0]  root_r,
    output logic [31:0]                          divisor
);

    logic [31:0] divisor_reg;
    logic [spas_pkg::ROOT_BITS-1:0] peak;

    assign peak = (root_l > root_r) ? root_l : root_r;

    always_ff @(posedge aclk) begin
        if (capture) begin
            divisor_reg <= {1'b0, peak} + 32'd1;
        end
    end

    assign divisor = divisor_reg;

endmodule

`default_nettype wire

// ===== rtl/stereo_preemphasis_agc_scaler_top.sv =====
// Top level of the stereo pre-emphasis / RMS AGC / level scaler.
// Depends on spas_pkg, spas_lane, spas_merge and the defines header.
`default_nettype none
`include "stereo_preemphasis_agc_scaler_top_defines.svh"

// Usage
//   s_valid/s_ready/s_word carry one stereo word (left and right Q1.23 samples).
//   m_valid/m_ready/m_word return one word per input: Q16.15 left and right
//   outputs and a clip flag. Registers are written through cfg_we/cfg_addr/
//   cfg_wdata, one per cycle, with no wait; write only while the block is idle.
//   Writing the initial power register also reloads both power smoothers.
// Operation
//   Two lanes, one per channel, work in parallel under one sequencer.
//   With RMS normalisation on, the bit-pair square root and the restoring
//   divider dominate the time from acceptance to the output register; with
//   normalisation off both are skipped. One word is in flight at a time;
//   s_ready is high only in the idle state, so a new word is taken only once
//   the previous result has moved to the output register.
// Reset and stalls
//   aresetn (synchronous, active low) clears the sequencer, the output valid,
//   the registers to their defaults, the previous samples and both smoothers.
//   A stalled receiver holds m_word; the next word may be accepted and worked
//   on meanwhile, and its result waits until the output register drains.
module stereo_preemphasis_agc_scaler_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire spas_pkg::in_word_t                  s_word,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output spas_pkg::out_word_t                      m_word,
    input  wire logic                                cfg_we,
    input  wire logic [spas_pkg::ADDR_BITS-1:0]      cfg_addr,
    input  wire logic [spas_pkg::DATA_BITS-1:0]      cfg_wdata
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_LOAD      = 4'd1;
    localparam logic [3:0] ST_SQUARE    = 4'd2;
    localparam logic [3:0] ST_SMOOTH_A  = 4'd3;
    localparam logic [3:0] ST_SMOOTH_B  = 4'd4;
    localparam logic [3:0] ST_SQRT_INIT = 4'd5;
    localparam logic [3:0] ST_SQRT_RUN  = 4'd6;
    localparam logic [3:0] ST_MERGE     = 4'd7;
    localparam logic [3:0] ST_DIV_INIT  = 4'd8;
    localparam logic [3:0] ST_DIV_RUN   = 4'd9;
    localparam logic [3:0] ST_BYPASS    = 4'd10;
    localparam logic [3:0] ST_LV_LO     = 4'd11;
    localparam logic [3:0] ST_LV_HI     = 4'd12;
    localparam logic [3:0] ST_LV_SUM    = 4'd13;
    localparam logic [3:0] ST_FIN       = 4'd14;

    localparam int CW = spas_pkg::CNT_BITS;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    spas_pkg::cfg_t      cfg_reg;
    logic                norm_en_reg;
    spas_pkg::in_word_t  in_reg;
    logic                m_valid_reg;
    spas_pkg::out_word_t m_word_reg;

    spas_pkg::lane_ctl_t ctl;
    spas_pkg::lane_res_t res_l, res_r;
    logic [spas_pkg::ROOT_BITS-1:0] root_l, root_r;
    logic [31:0]         divisor;
    logic                out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Register file: write on enable, drop indexes beyond the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preemph_enable <= 1'b0;
            cfg_reg.preemph_coef   <= 16'd63570;
            cfg_reg.agc_decay      <= 16'd65534;
            cfg_reg.level_enable   <= 1'b0;
            cfg_reg.level_gain     <= 32'd65536;
            norm_en_reg            <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                spas_pkg::REG_PREEMPH_ENABLE: cfg_reg.preemph_enable <= cfg_wdata[0];
                spas_pkg::REG_PREEMPH_COEF:   cfg_reg.preemph_coef   <= cfg_wdata[15:0];
                spas_pkg::REG_RMS_NORM_EN:    norm_en_reg            <= cfg_wdata[0];
                spas_pkg::REG_AGC_DECAY:      cfg_reg.agc_decay      <= cfg_wdata[15:0];
                spas_pkg::REG_LEVEL_ENABLE:   cfg_reg.level_enable   <= cfg_wdata[0];
                spas_pkg::REG_LEVEL_GAIN:     cfg_reg.level_gain     <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Sequencer: decode the state, and an initial power write, into lane strobes and advance.
    always_comb begin
        ctl          = '0;
        ctl.pow_load = cfg_we && (cfg_addr == spas_pkg::REG_AGC_INIT_POWER);
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctl.load   = 1'b1;
                state_next = norm_en_reg ? ST_SQUARE : ST_BYPASS;
            end
            ST_SQUARE: begin
                ctl.square = 1'b1;
                state_next = ST_SMOOTH_A;
            end
            ST_SMOOTH_A: begin
                ctl.smooth_a = 1'b1;
                state_next   = ST_SMOOTH_B;
            end
            ST_SMOOTH_B: begin
                ctl.smooth_b = 1'b1;
                state_next   = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                ctl.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT_RUN;
            end
            ST_SQRT_RUN: begin
                ctl.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(spas_pkg::SQRT_STEPS - 1)) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                ctl.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(spas_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_LV_LO;
                end
            end
            ST_BYPASS: begin
                ctl.bypass = 1'b1;
                state_next = ST_LV_LO;
            end
            ST_LV_LO: begin
                ctl.lv_lo  = 1'b1;
                state_next = ST_LV_HI;
            end
            ST_LV_HI: begin
                ctl.lv_hi  = 1'b1;
                state_next = ST_LV_SUM;
            end
            ST_LV_SUM: begin
                ctl.lv_sum = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the accepted word and the finished result.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_word;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_word_reg.left_out  <= res_l.value;
            m_word_reg.right_out <= res_r.value;
            m_word_reg.saturated <= res_l.sat | res_r.sat;
        end
    end

    spas_lane u_lane_l (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .pow_init (cfg_wdata),
        .sample   (in_reg.left_sample),
        .divisor  (divisor),
        .root     (root_l),
        .res      (res_l)
    );

    spas_lane u_lane_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .pow_init (cfg_wdata),
        .sample   (in_reg.right_sample),
        .divisor  (divisor),
        .root     (root_r),
        .res      (res_r)
    );

    spas_merge u_merge (
        .aclk    (aclk),
        .capture (state_reg == ST_MERGE),
        .root_l  (root_l),
        .root_r  (root_r),
        .divisor (divisor)
    );

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    `SPAS_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_valid && s_ready, state_reg == ST_LOAD, "accepted word did not start the lanes")
    `SPAS_ASSERT_NOW(a_sqrt_count, aclk, aresetn, state_reg == ST_SQRT_RUN, cnt_reg < CW'(spas_pkg::SQRT_STEPS), "root iteration count overran")
    `SPAS_ASSERT_NEXT(a_fin_waits, aclk, aresetn, state_reg == ST_FIN && m_valid && !m_ready, state_reg == ST_FIN && $stable(m_word), "result overwrote a stalled word")

endmodule

`default_nettype wire
